>>> hdl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `ASSERT_IMPLIES(lbl, clk, rst_n, 1'b1, !(cond))

`endif

>>> hdl/aarm_pkg.sv
// Types, constants and helper functions of the axis-angle rotation matrix core.
// No dependencies.
`default_nettype none
package aarm_pkg;

  localparam int CordicStagesDef = 24;

  localparam logic signed [26:0] Deg360 = 27'sd23592960;
  localparam logic signed [26:0] Deg180 = 27'sd11796480;
  localparam logic signed [26:0] Deg90  = 27'sd5898240;
  localparam logic [24:0]        Deg2Rad = 25'd18740330;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic signed [33:0] Q30One = 34'sd1073741824;

  typedef struct packed {
    logic signed [25:0] angle_deg;
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic               axis_zero;
  } out_t;

  // Classified transaction handed from front to back.
  typedef struct packed {
    logic              neg_s;
    logic              neg_c;
    logic              zero;
    logic signed [5:0] k;
    logic [2:0]        vneg;
    logic [2:0][31:0]  mag;
    logic [31:0]       rad;
    logic [63:0]       t;
  } fe_t;

  // State carried along the back-end chain.
  typedef struct packed {
    logic              neg_s;
    logic              neg_c;
    logic              zero;
    logic signed [5:0] k;
    logic [2:0]        vneg;
    logic [2:0][31:0]  mag;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] cz;
    logic [63:0]       t;
    logic [63:0]       res;
    logic [2:0][65:0]  rem;
    logic [2:0][33:0]  quo;
  } bk_t;

  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] r;
    case (i)
      0: r = 32'h3243F6A8;   1: r = 32'h1DAC6705;   2: r = 32'h0FADBAFC;
      3: r = 32'h07F56EA6;   4: r = 32'h03FEAB76;   5: r = 32'h01FFD55B;
      6: r = 32'h00FFFAAA;   7: r = 32'h007FFF55;   8: r = 32'h003FFFEA;
      9: r = 32'h001FFFFD;   10: r = 32'h000FFFFF;  11: r = 32'h0007FFFF;
      12: r = 32'h0003FFFF;  13: r = 32'h0001FFFF;  14: r = 32'h0000FFFF;
      15: r = 32'h00007FFF;  16: r = 32'h00003FFF;  17: r = 32'h00001FFF;
      18: r = 32'h00000FFF;  19: r = 32'h000007FF;  20: r = 32'h000003FF;
      21: r = 32'h000001FF;  22: r = 32'h000000FF;  23: r = 32'h0000007F;
      24: r = 32'h0000003F;  25: r = 32'h0000001F;  26: r = 32'h0000000F;
      27: r = 32'h00000008;  28: r = 32'h00000004;  29: r = 32'h00000002;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/aarm_front.sv
// Front end: folds the angle, forms radians, squares and normalizes the axis length.
// Depends on aarm_pkg.
`default_nettype none
module aarm_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  aarm_pkg::in_t      in_i,
  output logic               valid_o,
  output aarm_pkg::fe_t      fe_o
);
  import aarm_pkg::*;

  logic [5:0] vld_q;

  logic signed [26:0] a1_q;
  logic [2:0]         vneg1_q;
  logic [2:0][31:0]   mag1_q;

  logic               neg_s2_q, neg_c2_q;
  logic [22:0]        a2_q;
  logic [2:0][63:0]   sq2_q;
  logic [2:0]         vneg2_q;
  logic [2:0][31:0]   mag2_q;

  logic               neg_s3_q, neg_c3_q;
  logic [47:0]        prod3_q;
  logic [63:0]        sum3_q;
  logic [2:0]         vneg3_q;
  logic [2:0][31:0]   mag3_q;

  logic               neg_s4_q, neg_c4_q;
  logic [31:0]        rad4_q;
  logic [63:0]        sum4_q;
  logic [3:0]         nz4_q;
  logic [3:0][3:0]    pos4_q;
  logic [2:0]         vneg4_q;
  logic [2:0][31:0]   mag4_q;

  logic               neg_s5_q, neg_c5_q, zero5_q, large5_q;
  logic signed [5:0]  k5_q;
  logic [31:0]        rad5_q;
  logic [63:0]        sum5_q;
  logic [2:0]         vneg5_q;
  logic [2:0][31:0]   mag5_q;

  fe_t                fe_q;

  logic signed [26:0] a_wrap;
  logic [2:0][31:0]   mag_in;
  logic [2:0]         vneg_in;
  logic signed [26:0] a_abs;
  logic               neg_c_d;
  logic [3:0]         nz_d;
  logic [3:0][3:0]    pos_d;
  logic [5:0]         p_d;
  logic [5:0]         shamt;

  always_comb begin
    a_wrap = {in_i.angle_deg[25], in_i.angle_deg};
    if (a_wrap > Deg180) begin
      a_wrap = a_wrap - Deg360;
    end
    if (a_wrap < -Deg180) begin
      a_wrap = a_wrap + Deg360;
    end
    vneg_in = {in_i.axis_z[31], in_i.axis_y[31], in_i.axis_x[31]};
    mag_in[0] = in_i.axis_x[31] ? 32'(-in_i.axis_x) : in_i.axis_x;
    mag_in[1] = in_i.axis_y[31] ? 32'(-in_i.axis_y) : in_i.axis_y;
    mag_in[2] = in_i.axis_z[31] ? 32'(-in_i.axis_z) : in_i.axis_z;
  end

  always_comb begin
    a_abs = a1_q[26] ? -a1_q : a1_q;
    neg_c_d = 1'b0;
    if (a_abs > Deg90) begin
      a_abs = Deg180 - a_abs;
      neg_c_d = 1'b1;
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      nz_d[c] = |sum3_q[c*16 +: 16];
      pos_d[c] = 4'd0;
      for (int b = 0; b < 16; b++) begin
        if (sum3_q[c*16 + b]) begin
          pos_d[c] = 4'(b);
        end
      end
    end
    p_d = 6'd0;
    for (int c = 0; c < 4; c++) begin
      if (nz4_q[c]) begin
        p_d = {2'(c), pos4_q[c]};
      end
    end
    shamt = {k5_q[4:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q    <= a_wrap;
    vneg1_q <= vneg_in;
    mag1_q  <= mag_in;

    neg_s2_q <= a1_q[26];
    neg_c2_q <= neg_c_d;
    a2_q     <= a_abs[22:0];
    for (int j = 0; j < 3; j++) begin
      sq2_q[j] <= 64'(mag1_q[j]) * 64'(mag1_q[j]);
    end
    vneg2_q <= vneg1_q;
    mag2_q  <= mag1_q;

    neg_s3_q <= neg_s2_q;
    neg_c3_q <= neg_c2_q;
    prod3_q  <= 48'(a2_q) * 48'(Deg2Rad);
    sum3_q   <= sq2_q[0] + sq2_q[1] + sq2_q[2];
    vneg3_q  <= vneg2_q;
    mag3_q   <= mag2_q;

    neg_s4_q <= neg_s3_q;
    neg_c4_q <= neg_c3_q;
    rad4_q   <= 32'((prod3_q + 48'd32768) >> 16);
    sum4_q   <= sum3_q;
    nz4_q    <= nz_d;
    pos4_q   <= pos_d;
    vneg4_q  <= vneg3_q;
    mag4_q   <= mag3_q;

    neg_s5_q  <= neg_s4_q;
    neg_c5_q  <= neg_c4_q;
    zero5_q   <= ~|nz4_q;
    large5_q  <= p_d >= 6'd62;
    k5_q      <= (p_d >= 6'd62) ? -6'sd1 : 6'((6'd61 - p_d) >> 1);
    rad5_q    <= rad4_q;
    sum5_q    <= sum4_q;
    vneg5_q   <= vneg4_q;
    mag5_q    <= mag4_q;

    fe_q.neg_s <= neg_s5_q;
    fe_q.neg_c <= neg_c5_q;
    fe_q.zero  <= zero5_q;
    fe_q.k     <= k5_q;
    fe_q.vneg  <= vneg5_q;
    fe_q.mag   <= mag5_q;
    fe_q.rad   <= rad5_q;
    fe_q.t     <= large5_q ? (sum5_q >> 2) : (sum5_q << shamt);
  end

  assign valid_o = vld_q[5];
  assign fe_o    = fe_q;

endmodule
`default_nettype wire

>>> hdl/aarm_fifo.sv
// Two-entry queue between the front and back ends.
// Depends on aarm_pkg.
`default_nettype none
module aarm_fifo (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  aarm_pkg::fe_t  data_i,
  input  wire logic      pop_i,
  output logic           valid_o,
  output logic           full_o,
  output aarm_pkg::fe_t  data_o
);
  import aarm_pkg::*;

  fe_t        mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_pop, do_push;

  assign do_pop  = pop_i && (cnt_q != 2'd0);
  assign do_push = push_i && (cnt_q != 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign data_o  = mem_q[rd_q];

endmodule
`default_nettype wire

>>> hdl/aarm_back.sv
// Back end: CORDIC, square root and divider chain, then the Rodrigues products.
// Depends on aarm_pkg.
`default_nettype none
module aarm_back #(
  parameter int CORDIC_STAGES = aarm_pkg::CordicStagesDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  input  aarm_pkg::fe_t  fe_i,
  output logic           valid_o,
  output aarm_pkg::out_t out_o
);
  import aarm_pkg::*;

  localparam int NumSq    = 32;
  localparam int NumDiv   = 34;
  localparam int ChainLen = CORDIC_STAGES + NumSq + 1 + NumDiv;

  bk_t                 pipe [ChainLen+1];
  logic [ChainLen:0]   vld_q;
  logic [4:0]          tv_q;

  always_comb begin
    pipe[0]       = '0;
    pipe[0].neg_s = fe_i.neg_s;
    pipe[0].neg_c = fe_i.neg_c;
    pipe[0].zero  = fe_i.zero;
    pipe[0].k     = fe_i.k;
    pipe[0].vneg  = fe_i.vneg;
    pipe[0].mag   = fe_i.mag;
    pipe[0].cx    = CordicGain;
    pipe[0].cz    = {2'b00, fe_i.rad};
    pipe[0].t     = fe_i.t;
  end

  for (genvar j = 0; j < ChainLen; j++) begin : g_st
    bk_t nxt;
    if (j < CORDIC_STAGES) begin : g_cor
      always_comb begin
        logic signed [33:0] cx, cy, at;
        cx = pipe[j].cx;
        cy = pipe[j].cy;
        at = {2'b00, atan_q30(j)};
        nxt = pipe[j];
        if (!pipe[j].cz[33]) begin
          nxt.cx = cx - (cy >>> j);
          nxt.cy = cy + (cx >>> j);
          nxt.cz = pipe[j].cz - at;
        end else begin
          nxt.cx = cx + (cy >>> j);
          nxt.cy = cy - (cx >>> j);
          nxt.cz = pipe[j].cz + at;
        end
      end
    end else if (j < CORDIC_STAGES + NumSq) begin : g_sq
      localparam int Bp = 62 - 2 * (j - CORDIC_STAGES);
      always_comb begin
        logic [63:0] rb;
        rb  = pipe[j].res + (64'd1 << Bp);
        nxt = pipe[j];
        if (pipe[j].t >= rb) begin
          nxt.t   = pipe[j].t - rb;
          nxt.res = (pipe[j].res >> 1) + (64'd1 << Bp);
        end else begin
          nxt.res = pipe[j].res >> 1;
        end
      end
    end else if (j == CORDIC_STAGES + NumSq) begin : g_num
      always_comb begin
        logic [5:0] sh;
        sh  = 6'(6'd30 + pipe[j].k);
        nxt = pipe[j];
        for (int c = 0; c < 3; c++) begin
          nxt.rem[c] = 66'((64'(pipe[j].mag[c]) << sh) + (pipe[j].res >> 1));
          nxt.quo[c] = '0;
        end
      end
    end else begin : g_div
      localparam int Qb = NumDiv - 1 - (j - CORDIC_STAGES - NumSq - 1);
      always_comb begin
        logic [65:0] dv;
        dv  = 66'(pipe[j].res) << Qb;
        nxt = pipe[j];
        for (int c = 0; c < 3; c++) begin
          if (pipe[j].rem[c] >= dv) begin
            nxt.rem[c]     = pipe[j].rem[c] - dv;
            nxt.quo[c][Qb] = 1'b1;
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      pipe[j+1] <= nxt;
    end
  end

  // Tail: unit axis and trig terms, products, rounding, assembly.
  bk_t                     tl;
  logic signed [31:0]      u_d [3];
  logic signed [31:0]      c_d, s_d;
  logic signed [31:0]      x1_q [3];
  logic signed [31:0]      c1_q, s1_q;
  logic signed [32:0]      omc1_q;
  logic                    z1_q;
  logic signed [63:0]      p2_q [9];
  logic signed [31:0]      c2_q;
  logic signed [32:0]      omc2_q;
  logic                    z2_q;
  logic signed [33:0]      r3_q [9];
  logic signed [31:0]      c3_q;
  logic signed [32:0]      omc3_q;
  logic                    z3_q;
  logic signed [67:0]      q4_q [6];
  logic signed [33:0]      sx4_q [3];
  logic signed [31:0]      c4_q;
  logic                    z4_q;
  logic signed [33:0]      r3_d [9];
  logic signed [35:0]      e_d [6];
  out_t                    out_q;

  assign tl = pipe[ChainLen];

  always_comb begin
    logic [33:0]        uq;
    logic signed [33:0] cc, ss;
    for (int c = 0; c < 3; c++) begin
      uq = (tl.quo[c] > 34'd1073741824) ? 34'd1073741824 : tl.quo[c];
      if (tl.zero) begin
        u_d[c] = '0;
      end else begin
        u_d[c] = tl.vneg[c] ? -uq[31:0] : uq[31:0];
      end
    end
    cc = (tl.cx > Q30One) ? Q30One : ((tl.cx < -Q30One) ? -Q30One : tl.cx);
    ss = (tl.cy > Q30One) ? Q30One : ((tl.cy < -Q30One) ? -Q30One : tl.cy);
    c_d = tl.neg_c ? -cc[31:0] : cc[31:0];
    s_d = tl.neg_s ? -ss[31:0] : ss[31:0];
  end

  always_comb begin
    logic signed [63:0] rt;
    logic signed [67:0] qt;
    for (int i = 0; i < 9; i++) begin
      rt = p2_q[i] + 64'sd536870912;
      r3_d[i] = 34'(rt >>> 30);
    end
    for (int i = 0; i < 6; i++) begin
      qt = q4_q[i] + 68'sd536870912;
      e_d[i] = 36'(qt >>> 30);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[ChainLen:1] <= '0;
      tv_q <= '0;
    end else begin
      vld_q[ChainLen:1] <= vld_q[ChainLen-1:0];
      tv_q <= {tv_q[3:0], vld_q[ChainLen]};
    end
  end
  assign vld_q[0] = valid_i;

  always_ff @(posedge clk_i) begin
    x1_q   <= u_d;
    c1_q   <= c_d;
    s1_q   <= s_d;
    omc1_q <= 33'sd1073741824 - 33'(c_d);
    z1_q   <= tl.zero;

    p2_q[0] <= x1_q[0] * x1_q[0];
    p2_q[1] <= x1_q[1] * x1_q[1];
    p2_q[2] <= x1_q[2] * x1_q[2];
    p2_q[3] <= x1_q[0] * x1_q[1];
    p2_q[4] <= x1_q[0] * x1_q[2];
    p2_q[5] <= x1_q[1] * x1_q[2];
    p2_q[6] <= x1_q[0] * s1_q;
    p2_q[7] <= x1_q[1] * s1_q;
    p2_q[8] <= x1_q[2] * s1_q;
    c2_q    <= c1_q;
    omc2_q  <= omc1_q;
    z2_q    <= z1_q;

    r3_q   <= r3_d;
    c3_q   <= c2_q;
    omc3_q <= omc2_q;
    z3_q   <= z2_q;

    for (int i = 0; i < 6; i++) begin
      q4_q[i] <= r3_q[i] * omc3_q;
    end
    sx4_q[0] <= r3_q[6];
    sx4_q[1] <= r3_q[7];
    sx4_q[2] <= r3_q[8];
    c4_q     <= c3_q;
    z4_q     <= z3_q;

    out_q.m00 <= sat32(e_d[0] + 36'(c4_q));
    out_q.m11 <= sat32(e_d[1] + 36'(c4_q));
    out_q.m22 <= sat32(e_d[2] + 36'(c4_q));
    out_q.m01 <= sat32(e_d[3] - 36'(sx4_q[2]));
    out_q.m10 <= sat32(e_d[3] + 36'(sx4_q[2]));
    out_q.m02 <= sat32(e_d[4] + 36'(sx4_q[1]));
    out_q.m20 <= sat32(e_d[4] - 36'(sx4_q[1]));
    out_q.m12 <= sat32(e_d[5] - 36'(sx4_q[0]));
    out_q.m21 <= sat32(e_d[5] + 36'(sx4_q[0]));
    out_q.axis_zero <= z4_q;
  end

  assign valid_o = tv_q[4];
  assign out_o   = out_q;

endmodule
`default_nettype wire

>>> hdl/axis_angle_rotation_matrix_core.sv
// Axis-angle to 3x3 rotation matrix core: takes one transaction per clock cycle
// while busy is low. A taken transaction passes the front end, queue, CORDIC,
// 32-step square root, 34-step dividers and product tail, in that order;
// results appear once, in order, and cannot be held off by the receiver. busy only
// rises if the internal queue were full, which the free-running back end prevents.
// Depends on aarm_pkg, aarm_front, aarm_fifo, aarm_back.
`default_nettype none
module axis_angle_rotation_matrix_core #(
  parameter int CORDIC_STAGES = aarm_pkg::CordicStagesDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  aarm_pkg::in_t   in_i,
  output logic            out_valid_o,
  output aarm_pkg::out_t  out_o
);
  import aarm_pkg::*;

  logic fe_valid, q_valid, q_full;
  fe_t  fe_data, q_data;

  assign busy = q_full;

  aarm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .in_i    (in_i),
    .valid_o (fe_valid),
    .fe_o    (fe_data)
  );

  aarm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_valid),
    .data_i  (fe_data),
    .pop_i   (1'b1),
    .valid_o (q_valid),
    .full_o  (q_full),
    .data_o  (q_data)
  );

  aarm_back #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .fe_i    (q_data),
    .valid_o (out_valid_o),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire

>>> hdl/aarm_checker.sv
// Port-level checks of the rotation matrix core, bound to the top level.
// Depends on aarm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module aarm_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            busy,
  input aarm_pkg::out_t       out_o,
  input wire logic            out_valid_o
);
  import aarm_pkg::*;

  `ASSERT_IMPLIES(a_zero_offdiag, clk_i, rst_ni, out_valid_o && out_o.axis_zero, (out_o.m01 == 0) && (out_o.m02 == 0) && (out_o.m10 == 0) && (out_o.m12 == 0) && (out_o.m20 == 0) && (out_o.m21 == 0))
  `ASSERT_IMPLIES(a_zero_diag, clk_i, rst_ni, out_valid_o && out_o.axis_zero, (out_o.m00 == out_o.m11) && (out_o.m11 == out_o.m22))
  `ASSERT_IMPLIES(a_zero_cos, clk_i, rst_ni, out_valid_o && out_o.axis_zero, (out_o.m00 >= -32'sd1073741824) && (out_o.m00 <= 32'sd1073741824))
  `ASSERT_NEVER(a_no_busy, clk_i, rst_ni, busy && $past(busy))

endmodule

bind axis_angle_rotation_matrix_core aarm_checker u_aarm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .busy        (busy),
  .out_o       (out_o),
  .out_valid_o (out_valid_o)
);
`default_nettype wire

>>> tb/axis_angle_rotation_matrix_core_test.sv
// Testbench for the axis-angle rotation matrix core: directed and random
// transactions, a bit-exact predictor of the nine Q2.30 elements and checking.
// Depends on aarm_pkg and axis_angle_rotation_matrix_core.
`default_nettype none
module axis_angle_rotation_matrix_core_test;
  import aarm_pkg::*;

  localparam int Stages = CordicStagesDef;
  localparam int Latency = Stages + 79;
  localparam longint One = 64'sd1073741824;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_i = '0;
  logic out_valid_o;
  out_t out_o;

  in_t pending_q[$];
  out_t matrix_q[$];
  int mismatches = 0;
  int gap = 0;

  axis_angle_rotation_matrix_core #(.CORDIC_STAGES(Stages)) u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .in_i(in_i), .out_valid_o(out_valid_o), .out_o(out_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint asr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return asr(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] t);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > t) b = b >> 2;
    while (b != 0) begin
      if (t >= res + b) begin
        t = t - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unit_part(longint v, int k, logic [63:0] q);
    logic [63:0] mg;
    logic [63:0] num;
    longint u;
    mg = v < 0 ? -v : v;
    num = mg << (30 + k);
    u = longint'((num + (q >> 1)) / q);
    if (u > One) u = One;
    return v < 0 ? -u : u;
  endfunction

  function automatic out_t rotation_matrix(in_t it);
    longint a, cx, cy, cz, dx, dy, c, s, omc, xy, xz, yz, xs, ys, zs;
    longint v[3];
    longint u[3];
    longint m[9];
    logic [63:0] sum, t, q, mg;
    bit neg_s, neg_c;
    int p, k;
    out_t r;
    a = it.angle_deg;
    v[0] = it.axis_x; v[1] = it.axis_y; v[2] = it.axis_z;
    neg_c = 0;
    if (a > Deg180) a -= Deg360;
    if (a < -Deg180) a += Deg360;
    neg_s = a < 0;
    if (neg_s) a = -a;
    if (a > Deg90) begin
      a = Deg180 - a;
      neg_c = 1;
    end
    cx = CordicGain;
    cy = 0;
    cz = (a * Deg2Rad + 32768) >>> 16;
    for (int i = 0; i < Stages && i < 32; i++) begin
      dx = asr(cy, i);
      dy = asr(cx, i);
      if (cz >= 0) begin
        cx -= dx; cy += dy; cz -= longint'(atan_q30(i));
      end else begin
        cx += dx; cy -= dy; cz += longint'(atan_q30(i));
      end
    end
    c = clampv(cx, -One, One);
    s = clampv(cy, -One, One);
    if (neg_c) c = -c;
    if (neg_s) s = -s;
    omc = One - c;
    sum = 0;
    for (int j = 0; j < 3; j++) begin
      mg = v[j] < 0 ? -v[j] : v[j];
      sum += mg * mg;
    end
    r.axis_zero = (sum == 0);
    u[0] = 0; u[1] = 0; u[2] = 0;
    if (sum != 0) begin
      p = -1;
      for (int j = 63; j >= 0; j--) begin
        if (sum[j] && p < 0) p = j;
      end
      if (p >= 62) begin
        k = -1;
        t = sum >> 2;
      end else begin
        k = (61 - p) / 2;
        t = sum << (2 * k);
      end
      q = int_sqrt(t);
      for (int j = 0; j < 3; j++) u[j] = unit_part(v[j], k, q);
    end
    xy = qmul(qmul(u[0], u[1]), omc);
    xz = qmul(qmul(u[0], u[2]), omc);
    yz = qmul(qmul(u[1], u[2]), omc);
    xs = qmul(u[0], s); ys = qmul(u[1], s); zs = qmul(u[2], s);
    m[0] = qmul(qmul(u[0], u[0]), omc) + c;
    m[1] = xy - zs; m[2] = xz + ys; m[3] = xy + zs;
    m[4] = qmul(qmul(u[1], u[1]), omc) + c;
    m[5] = yz - xs; m[6] = xz - ys; m[7] = yz + xs;
    m[8] = qmul(qmul(u[2], u[2]), omc) + c;
    for (int i = 0; i < 9; i++) m[i] = clampv(m[i], -64'sd2147483648, 64'sd2147483647);
    r.m00 = 32'(m[0]); r.m01 = 32'(m[1]); r.m02 = 32'(m[2]);
    r.m10 = 32'(m[3]); r.m11 = 32'(m[4]); r.m12 = 32'(m[5]);
    r.m20 = 32'(m[6]); r.m21 = 32'(m[7]); r.m22 = 32'(m[8]);
    return r;
  endfunction

  function automatic in_t make_item(longint ang, longint x, longint y, longint z);
    in_t it;
    it.angle_deg = 26'(ang); it.axis_x = 32'(x); it.axis_y = 32'(y); it.axis_z = 32'(z);
    return it;
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'(int'($urandom_range(0, 131072)) - 65536);
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      4: return 32'(int'($urandom_range(0, 255)) - 128);
      default: return 32'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
    endcase
  endfunction

  function automatic logic [25:0] rand_angle();
    case ($urandom_range(0, 4))
      0: return 26'($urandom());
      1: return 26'(int'($urandom_range(0, 47185920)) - 23592960);
      2: return 26'(int'($urandom_range(0, 720)) * 65536 - 23592960);
      default: return 26'(int'($urandom_range(0, 2 * 5898240)) - 5898240);
    endcase
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      gap <= 0;
    end else begin
      if (start && !busy) begin
        matrix_q.push_back(rotation_matrix(in_i));
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_i <= pending_q.pop_front();
        start <= 1'b1;
        case ($urandom_range(0, 9))
          0, 1: gap <= $urandom_range(1, 3);
          2: gap <= $urandom_range(10, 40);
          default: gap <= 0;
        endcase
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (matrix_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", out_o);
      end else begin
        out_t exp_m;
        exp_m = matrix_q.pop_front();
        if (out_o !== exp_m) begin
          mismatches++;
          if (mismatches <= 10) $display("expected %p\n  actual %p", exp_m, out_o);
        end
      end
    end
  end

  initial begin
    longint dirs[10];
    dirs = '{0, 23592960, -23592960, 11796480, -11796480, 5898240, -5898240,
             33554431, -33554432, 2949120};
    foreach (dirs[i]) pending_q.push_back(make_item(dirs[i], 65536, 0, 0));
    pending_q.push_back(make_item(2949120, 0, 0, 0));
    pending_q.push_back(make_item(-2949120, 0, 0, 0));
    pending_q.push_back(make_item(1966080, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
    pending_q.push_back(make_item(1966080, -2147483648, -2147483648, -2147483648));
    pending_q.push_back(make_item(-1966080, -2147483648, 32'h7FFFFFFF, 0));
    pending_q.push_back(make_item(5898240, 0, 65536, 0));
    pending_q.push_back(make_item(5898240, 0, 0, -65536));
    pending_q.push_back(make_item(7000000, 1, -1, 1));
    pending_q.push_back(make_item(-9000000, 37837, 37837, 37837));
    pending_q.push_back(make_item(20000000, -65536, 0, 0));
    for (int i = 0; i < 1000; i++) begin
      pending_q.push_back(make_item(longint'($signed(rand_angle())),
        longint'($signed(rand_comp())), longint'($signed(rand_comp())),
        longint'($signed(rand_comp()))));
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0 && !start);
    wait (matrix_q.size() == 0);
    repeat (Latency + 10) @(posedge clk_i);
    if (mismatches == 0 && matrix_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
